/* design/lsm_pkg.sv */
package lsm_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned MaxRingsDef  = 21;

  localparam int unsigned PointXW = 9;
  localparam int unsigned PointYW = 8;
  localparam int unsigned CountW  = 7;
  localparam int unsigned RingW   = 5;
  localparam int unsigned StepW   = 16;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned CoordW  = 18;
  localparam int unsigned AccW    = 36;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RING_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COS_STEP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SIN_STEP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y    = 3'd5;

  localparam logic [CountW-1:0]  RST_POINT_COUNT = 7'd8;
  localparam logic [RingW-1:0]   RST_RING_COUNT  = 5'd8;
  localparam logic [StepW-1:0]   RST_COS_STEP    = 16'd23226;
  localparam logic [StepW-1:0]   RST_SIN_STEP    = 16'd23114;
  localparam logic [PointXW-1:0] RST_CENTER_X    = 9'd159;
  localparam logic [PointYW-1:0] RST_CENTER_Y    = 8'd119;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  localparam logic signed [AccW-1:0] ROUND_HALF = 36'sd16384;

  // floor of acc / 2^15, clamped to the coordinate range
  function automatic logic signed [CoordW-1:0] sat_q15(input logic signed [AccW-1:0] acc);
    logic signed [AccW-16:0] sh;
    sh = (AccW-15)'(acc >>> 15);
    if (sh > 21'sd131071) begin
      sat_q15 = 18'sd131071;
    end else if (sh < -21'sd131072) begin
      sat_q15 = -18'sd131072;
    end else begin
      sat_q15 = CoordW'(sh);
    end
  endfunction

endpackage

/* design/lsm_intf.sv */
interface lsm_in_if
  import lsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PointXW-1:0] point_x;
  logic [PointYW-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface lsm_out_if
  import lsm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     item_kind;
  logic [IndexW-1:0]        vertex_index;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  logic [IndexW-1:0]        corner_a;
  logic [IndexW-1:0]        corner_b;
  logic [IndexW-1:0]        corner_c;
  logic                     run_last;

  modport source (output valid, item_kind, vertex_index, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, run_last, input ready);
  modport sink   (input valid, item_kind, vertex_index, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, run_last, output ready);
endinterface

/* design/lathe_surface_mesh_generator.sv */
// channel   | dir | payload
// ----------+-----+--------------------------------------------------------------
// in_i      | in  | point_x, point_y: one profile point per beat
// out_o     | out | item_kind, vertex_index, coord_x/y/z, corner_a/b/c, run_last
// cfg port  | in  | cfg_we_i, cfg_idx_i, cfg_data_i: one register write per cycle
//
// A point emits a vertex beat per ring plus a closing vertex, then, unless it is the
// first point of an outline, two triangle beats per ring; any beat waits while the sink holds ready low.
// Each ring runs four products plus a saturate step on the single 18x16
// multiplier-accumulator, then hands over the vertex beat.
// in_i is ready only while no point is in work; out_o holds its beat until taken.
// rst_ni clears the point counter and loads the register defaults.
module lathe_surface_mesh_generator
  import lsm_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef,
  parameter int unsigned MAX_RINGS  = MaxRingsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  lsm_in_if.sink             in_i,
  lsm_out_if.source          out_o
);

  localparam int unsigned PnW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned RcW = $clog2(MAX_RINGS + 1);
  localparam logic [CountW-1:0] MaxP = CountW'(MAX_POINTS);
  localparam logic [RingW-1:0]  MaxR = RingW'(MAX_RINGS);

  localparam logic [2:0] PH_X_COS  = 3'd0;
  localparam logic [2:0] PH_Y_SIN  = 3'd1;
  localparam logic [2:0] PH_Y_COS  = 3'd2;
  localparam logic [2:0] PH_X_SIN  = 3'd3;
  localparam logic [2:0] PH_FINISH = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_VOUT,
    ST_COPY,
    ST_TRI
  } state_e;

  // configuration registers
  logic [CountW-1:0]  point_count_q;
  logic [RingW-1:0]   ring_count_q;
  logic [StepW-1:0]   cos_step_q;
  logic [StepW-1:0]   sin_step_q;
  logic [PointXW-1:0] center_x_q;
  logic [PointYW-1:0] center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= RST_POINT_COUNT;
      ring_count_q  <= RST_RING_COUNT;
      cos_step_q    <= RST_COS_STEP;
      sin_step_q    <= RST_SIN_STEP;
      center_x_q    <= RST_CENTER_X;
      center_y_q    <= RST_CENTER_Y;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POINT_COUNT: point_count_q <= cfg_data_i[CountW-1:0];
        CFG_RING_COUNT:  ring_count_q  <= cfg_data_i[RingW-1:0];
        CFG_COS_STEP:    cos_step_q    <= cfg_data_i[StepW-1:0];
        CFG_SIN_STEP:    sin_step_q    <= cfg_data_i[StepW-1:0];
        CFG_CENTER_X:    center_x_q    <= cfg_data_i[PointXW-1:0];
        CFG_CENTER_Y:    center_y_q    <= cfg_data_i[PointYW-1:0];
        default: ;
      endcase
    end
  end

  state_e                   state_q;
  logic [2:0]               phase_q;
  logic [PnW-1:0]           point_number_q;
  logic [PnW-1:0]           pn_q;
  logic [CountW-1:0]        p_q;
  logic [RingW-1:0]         r_q;
  logic [RcW-1:0]           ring_q;
  logic                     sub_q;
  logic [IndexW-1:0]        base_q;
  logic signed [CoordW-1:0] x_q, y_q, z_q, nx_q, x0_q, y0_q;
  logic signed [AccW-1:0]   acc_q;

  logic                     out_valid_q;
  logic                     kind_q;
  logic [IndexW-1:0]        vidx_q;
  logic signed [CoordW-1:0] ox_q, oy_q, oz_q;
  logic [IndexW-1:0]        ca_q, cb_q, cc_q;
  logic                     last_q;

  // clamp counts and point number at accept time
  logic [CountW-1:0]  p_clamp;
  logic [RingW-1:0]   r_clamp;
  logic [PnW-1:0]     pn_clamp;
  logic [CountW-1:0]  pn_next;
  logic signed [9:0]  rad_diff;
  logic signed [8:0]  hgt_diff;

  always_comb begin
    if (point_count_q < 7'd2) begin
      p_clamp = 7'd2;
    end else if (point_count_q > MaxP) begin
      p_clamp = MaxP;
    end else begin
      p_clamp = point_count_q;
    end
    if (ring_count_q == 5'd0) begin
      r_clamp = 5'd1;
    end else if (ring_count_q > MaxR) begin
      r_clamp = MaxR;
    end else begin
      r_clamp = ring_count_q;
    end
    pn_clamp = (CountW'(point_number_q) >= p_clamp) ? '0 : point_number_q;
    pn_next  = CountW'(pn_clamp) + 7'd1;
    rad_diff = $signed({1'b0, in_i.point_x}) - $signed({1'b0, center_x_q});
    hgt_diff = $signed({1'b0, in_i.point_y}) - $signed({1'b0, center_y_q});
  end

  // shared multiplier-accumulator
  logic signed [CoordW-1:0]     mul_a;
  logic signed [StepW-1:0]      mul_b;
  logic signed [CoordW+StepW-1:0] prod;
  logic signed [AccW-1:0]       prod_x;
  logic signed [AccW-1:0]       acc_d;
  logic signed [CoordW-1:0]     acc_sat;

  always_comb begin
    mul_a = ((phase_q == PH_Y_SIN) || (phase_q == PH_Y_COS)) ? y_q : x_q;
    mul_b = ((phase_q == PH_X_COS) || (phase_q == PH_Y_COS)) ?
            $signed(cos_step_q) : $signed(sin_step_q);
    prod   = mul_a * mul_b;
    prod_x = AccW'(prod);
    case (phase_q)
      PH_X_COS, PH_Y_COS: acc_d = prod_x + ROUND_HALF;
      PH_Y_SIN:           acc_d = acc_q - prod_x;
      PH_X_SIN:           acc_d = acc_q + prod_x;
      default:            acc_d = acc_q;
    endcase
    acc_sat = sat_q15(acc_q);
  end

  logic              last_ring;
  logic [IndexW-1:0] tri_c;
  logic [IndexW-1:0] p_ext;
  logic [IndexW-1:0] pn_ext;

  always_comb begin
    last_ring = (RingW'(ring_q) == (r_q - 5'd1));
    p_ext     = IndexW'(p_q);
    pn_ext    = IndexW'(pn_q);
    tri_c     = base_q + pn_ext - 11'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= PH_X_COS;
      point_number_q <= '0;
      pn_q           <= '0;
      p_q            <= '0;
      r_q            <= '0;
      ring_q         <= '0;
      sub_q          <= 1'b0;
      base_q         <= '0;
      x_q            <= '0;
      y_q            <= '0;
      z_q            <= '0;
      nx_q           <= '0;
      x0_q           <= '0;
      y0_q           <= '0;
      acc_q          <= '0;
      out_valid_q    <= 1'b0;
      kind_q         <= KIND_VERTEX;
      vidx_q         <= '0;
      ox_q           <= '0;
      oy_q           <= '0;
      oz_q           <= '0;
      ca_q           <= '0;
      cb_q           <= '0;
      cc_q           <= '0;
      last_q         <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            p_q     <= p_clamp;
            r_q     <= r_clamp;
            pn_q    <= pn_clamp;
            point_number_q <= (pn_next >= p_clamp) ? '0 : PnW'(pn_next);
            x_q     <= '0;
            y_q     <= {rad_diff, 8'd0};
            z_q     <= {hgt_diff[8], hgt_diff, 8'd0};
            ring_q  <= '0;
            base_q  <= '0;
            phase_q <= PH_X_COS;
            state_q <= ST_ROT;
          end
        end
        ST_ROT: begin
          acc_q <= acc_d;
          if (phase_q == PH_Y_COS) begin
            nx_q <= acc_sat;
          end
          if (phase_q == PH_FINISH) begin
            x_q <= nx_q;
            y_q <= acc_sat;
            if (ring_q == '0) begin
              x0_q <= nx_q;
              y0_q <= acc_sat;
            end
            out_valid_q <= 1'b1;
            kind_q      <= KIND_VERTEX;
            vidx_q      <= base_q + pn_ext;
            ox_q        <= nx_q;
            oy_q        <= acc_sat;
            oz_q        <= z_q;
            ca_q        <= '0;
            cb_q        <= '0;
            cc_q        <= '0;
            last_q      <= 1'b0;
            state_q     <= ST_VOUT;
          end else begin
            phase_q <= phase_q + 3'd1;
          end
        end
        ST_VOUT: begin
          if (out_o.ready) begin
            if (last_ring) begin
              // closing ring repeats ring 0
              vidx_q  <= base_q + p_ext + pn_ext;
              ox_q    <= x0_q;
              oy_q    <= y0_q;
              last_q  <= (pn_q == '0);
              state_q <= ST_COPY;
            end else begin
              out_valid_q <= 1'b0;
              ring_q      <= ring_q + 1'b1;
              base_q      <= base_q + p_ext;
              phase_q     <= PH_X_COS;
              state_q     <= ST_ROT;
            end
          end
        end
        ST_COPY: begin
          if (out_o.ready) begin
            if (pn_q == '0) begin
              out_valid_q <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              ring_q  <= '0;
              sub_q   <= 1'b0;
              base_q  <= '0;
              kind_q  <= KIND_TRIANGLE;
              vidx_q  <= '0;
              ox_q    <= '0;
              oy_q    <= '0;
              oz_q    <= '0;
              ca_q    <= pn_ext - 11'd1;
              cb_q    <= pn_ext;
              cc_q    <= pn_ext + p_ext;
              last_q  <= 1'b0;
              state_q <= ST_TRI;
            end
          end
        end
        ST_TRI: begin
          if (out_o.ready) begin
            if (sub_q) begin
              if (last_ring) begin
                out_valid_q <= 1'b0;
                state_q     <= ST_IDLE;
              end else begin
                // first triangle of the next ring
                ring_q <= ring_q + 1'b1;
                base_q <= base_q + p_ext;
                sub_q  <= 1'b0;
                ca_q   <= tri_c + p_ext;
                cb_q   <= tri_c + p_ext + 11'd1;
                cc_q   <= tri_c + p_ext + p_ext + 11'd1;
              end
            end else begin
              sub_q  <= 1'b1;
              ca_q   <= tri_c;
              cb_q   <= tri_c + p_ext + 11'd1;
              cc_q   <= tri_c + p_ext;
              last_q <= last_ring;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.item_kind    = kind_q;
  assign out_o.vertex_index = vidx_q;
  assign out_o.coord_x      = ox_q;
  assign out_o.coord_y      = oy_q;
  assign out_o.coord_z      = oz_q;
  assign out_o.corner_a     = ca_q;
  assign out_o.corner_b     = cb_q;
  assign out_o.corner_c     = cc_q;
  assign out_o.run_last     = last_q;

endmodule

/* tb/sv/tb_lathe_surface_mesh_generator.sv */
module tb_lathe_surface_mesh_generator
  import lsm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PointXW-1:0] x;
    logic [PointYW-1:0] y;
  } profile_pt_t;

  typedef struct {
    logic                     kind;
    logic [IndexW-1:0]        vidx;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [IndexW-1:0]        ca;
    logic [IndexW-1:0]        cb;
    logic [IndexW-1:0]        cc;
    logic                     last;
  } mesh_rec_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  logic               in_valid  = 1'b0;
  logic [PointXW-1:0] in_x      = '0;
  logic [PointYW-1:0] in_y      = '0;
  logic               out_ready = 1'b0;

  lsm_in_if  in_if ();
  lsm_out_if out_if ();

  assign in_if.valid   = in_valid;
  assign in_if.point_x = in_x;
  assign in_if.point_y = in_y;
  assign out_if.ready  = out_ready;

  lathe_surface_mesh_generator dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // shadow registers and outline position
  logic [CountW-1:0]  sh_points = RST_POINT_COUNT;
  logic [RingW-1:0]   sh_rings  = RST_RING_COUNT;
  logic [StepW-1:0]   sh_cos    = RST_COS_STEP;
  logic [StepW-1:0]   sh_sin    = RST_SIN_STEP;
  logic [PointXW-1:0] sh_cx     = RST_CENTER_X;
  logic [PointYW-1:0] sh_cy     = RST_CENTER_Y;
  logic [5:0]         cur_point = '0;

  profile_pt_t profile_q[$];
  mesh_rec_t   mesh_expect_q[$];

  int  mismatches = 0;
  bit  steady     = 1'b0;
  int  in_beats   = 0;
  int  drv_beats  = 0;
  int  in_gap     = 0;
  bit  in_taken;
  int  hold_reqs  = 0;
  int  holds_done = 0;
  int  hold_left  = 0;
  int  ready_gap;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("lathe_surface_mesh_generator: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  task automatic push_rec(input logic kind, input longint idx, input longint x, input longint y,
                          input longint z, input longint a, input longint b, input longint c,
                          input logic last);
    mesh_rec_t rec;
    rec.kind = kind;
    rec.vidx = idx[IndexW-1:0];
    rec.cx   = x[CoordW-1:0];
    rec.cy   = y[CoordW-1:0];
    rec.cz   = z[CoordW-1:0];
    rec.ca   = a[IndexW-1:0];
    rec.cb   = b[IndexW-1:0];
    rec.cc   = c[IndexW-1:0];
    rec.last = last;
    mesh_expect_q.push_back(rec);
  endtask

  task automatic predict_point(input logic [PointXW-1:0] px, input logic [PointYW-1:0] py);
    longint npts, nrings, pn, cs, sn, x, y, z, nx, ny, x0, y0, c;
    npts = sh_points;
    if (npts < 2) npts = 2;
    if (npts > MaxPointsDef) npts = MaxPointsDef;
    nrings = sh_rings;
    if (nrings < 1) nrings = 1;
    if (nrings > MaxRingsDef) nrings = MaxRingsDef;
    pn = cur_point;
    // outline shortened mid-way: restart at point 0
    if (pn >= npts) pn = 0;
    cs = longint'($signed(sh_cos));
    sn = longint'($signed(sh_sin));
    x  = 0;
    y  = (longint'(px) - longint'(sh_cx)) * 256;
    z  = (longint'(py) - longint'(sh_cy)) * 256;
    x0 = 0;
    y0 = 0;
    for (longint r = 0; r < nrings; r++) begin
      nx = clamp_coord((x * cs - y * sn + 16384) >>> 15);
      ny = clamp_coord((y * cs + x * sn + 16384) >>> 15);
      x  = nx;
      y  = ny;
      if (r == 0) begin
        x0 = x;
        y0 = y;
      end
      push_rec(KIND_VERTEX, r * npts + pn, x, y, z, 0, 0, 0, 1'b0);
    end
    // closing ring repeats ring 0
    push_rec(KIND_VERTEX, nrings * npts + pn, x0, y0, z, 0, 0, 0, pn == 0);
    if (pn > 0) begin
      for (longint r = 0; r < nrings; r++) begin
        c = r * npts + pn - 1;
        push_rec(KIND_TRIANGLE, 0, 0, 0, 0, c, c + 1, c + npts + 1, 1'b0);
        push_rec(KIND_TRIANGLE, 0, 0, 0, 0, c, c + npts + 1, c + npts, r == nrings - 1);
      end
    end
    cur_point = (pn + 1 >= npts) ? 6'd0 : 6'(pn + 1);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    case (idx)
      CFG_POINT_COUNT: sh_points = data[CountW-1:0];
      CFG_RING_COUNT:  sh_rings  = data[RingW-1:0];
      CFG_COS_STEP:    sh_cos    = data[StepW-1:0];
      CFG_SIN_STEP:    sh_sin    = data[StepW-1:0];
      CFG_CENTER_X:    sh_cx     = data[PointXW-1:0];
      CFG_CENTER_Y:    sh_cy     = data[PointYW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(input int pc, input int rc, input logic [15:0] cs,
                           input logic [15:0] sn, input int cx, input int cy);
    write_reg(CFG_POINT_COUNT, CfgW'(pc));
    write_reg(CFG_RING_COUNT, CfgW'(rc));
    write_reg(CFG_COS_STEP, cs);
    write_reg(CFG_SIN_STEP, sn);
    write_reg(CFG_CENTER_X, CfgW'(cx));
    write_reg(CFG_CENTER_Y, CfgW'(cy));
  endtask

  task automatic add_point(input int x, input int y);
    profile_pt_t pt;
    pt.x = PointXW'(x);
    pt.y = PointYW'(y);
    profile_q.push_back(pt);
  endtask

  task automatic settle();
    while (profile_q.size() != 0 || in_valid || mesh_expect_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // input beats and output checking
  always @(posedge clk) begin
    mesh_rec_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        predict_point(in_if.point_x, in_if.point_y);
        in_beats++;
      end
      if (out_if.valid && out_if.ready) begin
        if (mesh_expect_q.size() == 0) begin
          $error("unexpected output beat, kind %0d", out_if.item_kind);
          mismatches++;
        end else begin
          want = mesh_expect_q.pop_front();
          check_field("item_kind", want.kind, out_if.item_kind);
          check_field("vertex_index", want.vidx, out_if.vertex_index);
          check_field("coord_x", want.cx, out_if.coord_x);
          check_field("coord_y", want.cy, out_if.coord_y);
          check_field("coord_z", want.cz, out_if.coord_z);
          check_field("corner_a", want.ca, out_if.corner_a);
          check_field("corner_b", want.cb, out_if.corner_b);
          check_field("corner_c", want.cc, out_if.corner_c);
          check_field("run_last", want.last, out_if.run_last);
        end
      end
    end
  end

  // point driver: hold the beat until taken, then advance after a gap
  always @(negedge clk) begin
    profile_pt_t pt;
    if (rst_n) begin
      in_taken  = (in_beats != drv_beats);
      drv_beats = in_beats;
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (profile_q.size() > 0) begin
          pt = profile_q.pop_front();
          in_x     <= pt.x;
          in_y     <= pt.y;
          in_valid <= 1'b1;
          in_gap   = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure, with a long hold on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_left  = 400;
        out_ready <= 1'b0;
      end else begin
        ready_gap = pick_gap();
        if (ready_gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          hold_left = ready_gap - 1;
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    int  pc, rc, rcl, cx, cy, cosv, sinv;
    real ang;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, one full outline of eight points
    add_point(0, 0);
    add_point(319, 239);
    add_point(159, 119);
    add_point(256, 128);
    add_point(191, 63);
    add_point(1, 1);
    add_point(318, 238);
    add_point(100, 200);
    settle();

    // smallest outline, one ring, identity rotation
    write_all(2, 1, 16'h7FFF, 16'h0000, 0, 0);
    add_point(319, 239);
    add_point(0, 0);
    add_point(319, 0);
    settle();

    // largest outline and ring count, growing step that saturates
    write_all(64, 21, 16'h8000, 16'h8000, 319, 239);
    add_point(0, 0);
    add_point(319, 239);
    add_point(0, 239);
    settle();

    // counts below range; point number now stale
    write_all(1, 0, 16'h0000, 16'h7FFF, 159, 119);
    add_point(0, 239);
    add_point(319, 0);
    add_point(160, 120);
    settle();

    // counts above range
    write_all(127, 31, 16'h8000, 16'h7FFF, 200, 50);
    add_point(319, 239);
    add_point(0, 0);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph % 3 == 1);
      case ($urandom_range(0, 9))
        0:       pc = $urandom_range(0, 127);
        1:       pc = 64;
        default: pc = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       rc = $urandom_range(0, 31);
        1:       rc = 21;
        default: rc = $urandom_range(1, 6);
      endcase
      rcl = (rc < 1) ? 1 : ((rc > 21) ? 21 : rc);
      if ($urandom_range(0, 4) == 0) begin
        cosv = $urandom_range(0, 65535);
        sinv = $urandom_range(0, 65535);
      end else begin
        // a real rotation that closes the circle after all rings
        ang  = 2.0 * 3.14159265358979 / rcl;
        cosv = $rtoi($cos(ang) * 32767.0);
        sinv = $rtoi($sin(ang) * 32767.0);
        if ($urandom_range(0, 1)) sinv = -sinv;
      end
      cx = $urandom_range(0, 319);
      cy = $urandom_range(0, 239);
      write_all(pc, rc, 16'(cosv), 16'(sinv), cx, cy);
      if (ph == 4) hold_reqs++;
      for (int k = 0; k < 42; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_point($urandom_range(0, 1) * 319, $urandom_range(0, 1) * 239);
        end else begin
          add_point($urandom_range(0, 319), $urandom_range(0, 239));
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("lathe_surface_mesh_generator: match");
    end else begin
      $display("lathe_surface_mesh_generator: mismatch");
    end
    $finish;
  end

endmodule
